// ----- sv/fram_pkg.sv -----
// -----------------------------------------------------------------------------
// fram_pkg: shared types and constants of the four-register ALU machine
//
// Holds the field widths, the operation codes and the command and status
// structs that pass between the controller and the datapath.
// -----------------------------------------------------------------------------
package fram_pkg;

	// Field widths of one input item.
	localparam int OP_W    = 3;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 64;

	// Packed input item, rounded up to whole bytes.
	localparam int IN_BITS  = OP_W + 2 * IDX_W + DATA_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

	// Bit positions inside the input tdata.
	localparam int OP_LSB  = 0;
	localparam int DST_LSB = OP_LSB + OP_W;
	localparam int SRC_LSB = DST_LSB + IDX_W;
	localparam int IMM_LSB = SRC_LSB + IDX_W;

	// Default size of the register file.
	localparam int REG_COUNT_DEF = 4;

	// One iteration step per operand bit for multiply and divide.
	localparam int STEP_CNT_W = $clog2(DATA_W);

	typedef logic [OP_W-1:0] op_t;

	// Operation codes.
	localparam op_t OP_LDI = 3'd0;
	localparam op_t OP_MOV = 3'd1;
	localparam op_t OP_ADD = 3'd2;
	localparam op_t OP_SUB = 3'd3;
	localparam op_t OP_MUL = 3'd4;
	localparam op_t OP_DIV = 3'd5;
	localparam op_t OP_OUT = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // take the input item and read both operands
		logic latch_opnd; // register the operand values
		logic init_mul;   // load the shift unit for a multiply
		logic init_div;   // load the shift unit for a divide
		logic step;       // one iteration of the shift unit
		logic wr_en;      // write the result to the destination
		logic load_out;   // load the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;       // operation of the item at work
		logic b_zero;   // source operand is zero
		logic out_busy; // output register holds an item that is not taken
	} ctrl_stat_t;

endpackage

// ----- sv/four_register_alu_machine.sv -----
// -----------------------------------------------------------------------------
// four_register_alu_machine: instruction engine on a small register file
//
// Executes one instruction per input item on REG_COUNT 64-bit registers.
// -----------------------------------------------------------------------------
// The block takes one item at a time. Load immediate, move, add, subtract,
// output, a divide by zero and the unused op code free the input after the
// operand read and execute states (an output waits longer while the previous
// output item is still not taken). Multiply and a divide by a nonzero value
// start the shared shift unit, which handles one operand bit per cycle over
// 64 bits between operand read and write-back. Registers read as zero after
// reset through per-register valid bits, so there is no clearing pass. An
// index at or beyond REG_COUNT reads as zero and is never written. Division
// by zero leaves the destination unchanged; the most negative value divided
// by minus one wraps to itself. Input tdata, from bit 0 up: op[2:0],
// dest_reg[4:3], src_reg[6:5], immediate[70:7], bit 71 zero. Output tdata
// carries out_value in bits 63:0.
module four_register_alu_machine #(
	parameter int REG_COUNT = fram_pkg::REG_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// op, dest_reg, src_reg, immediate
	input  logic [fram_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_value
	output logic [fram_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	import fram_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	fram_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fram_dp #(
		.REG_COUNT(REG_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- sv/fram_ram.sv -----
// -----------------------------------------------------------------------------
// fram_ram: generic RAM with one write port and two registered read ports
//
// Storage has no reset; read data appears in the cycle after the read enable.
// -----------------------------------------------------------------------------
module fram_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ----- sv/fram_dp.sv -----
// -----------------------------------------------------------------------------
// fram_dp: datapath of the four-register ALU machine
//
// Register file with valid bits, operand registers, a shared shift unit for
// bit-serial multiply and restoring divide, and the output register.
// -----------------------------------------------------------------------------
module fram_dp #(
	parameter int REG_COUNT = fram_pkg::REG_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fram_pkg::ctrl_cmd_t                 cmd,
	output fram_pkg::ctrl_stat_t                stat,
	input  logic [fram_pkg::IN_TDATA_W-1:0]     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fram_pkg::OUT_TDATA_W-1:0]    out_data
);

	import fram_pkg::*;

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// Input fields.
	op_t               in_op;
	logic [IDX_W-1:0]  in_dst;
	logic [IDX_W-1:0]  in_src;
	logic [DATA_W-1:0] in_imm;
	logic              in_dst_ok;
	logic              in_src_ok;

	// Captured item.
	op_t               op_q;
	logic [IDX_W-1:0]  dst_q;
	logic [DATA_W-1:0] imm_q;
	logic              dst_ok_q;
	logic              a_live_q;
	logic              b_live_q;

	// Register file.
	logic [REG_COUNT-1:0] valid_q;
	logic [DATA_W-1:0]    rd_a;
	logic [DATA_W-1:0]    rd_b;
	logic                 rf_wr;
	logic [DATA_W-1:0]    wr_data;

	// Operands and shift unit.
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] z_q;
	logic              neg_q;
	logic [DATA_W:0]   div_shift;
	logic [DATA_W:0]   div_trial;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;

	assign in_op  = in_data[OP_LSB +: OP_W];
	assign in_dst = in_data[DST_LSB +: IDX_W];
	assign in_src = in_data[SRC_LSB +: IDX_W];
	assign in_imm = in_data[IMM_LSB +: DATA_W];

	// An index at or beyond the register count reads as zero.
	assign in_dst_ok = (32'(in_dst) < REG_COUNT);
	assign in_src_ok = (32'(in_src) < REG_COUNT);

	fram_ram #(
		.WIDTH(DATA_W),
		.DEPTH(REG_COUNT)
	) u_rf (
		.clk       (clk),
		.wr_en     (rf_wr),
		.wr_addr   (AW'(dst_q)),
		.wr_data   (wr_data),
		.rd_en     (cmd.capture),
		.rd_addr_a (AW'(in_dst)),
		.rd_data_a (rd_a),
		.rd_addr_b (AW'(in_src)),
		.rd_data_b (rd_b)
	);

	// Capture the item; the register file reads both operands at the same edge.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			dst_q    <= in_dst;
			imm_q    <= in_imm;
			dst_ok_q <= in_dst_ok;
			a_live_q <= in_dst_ok ? valid_q[AW'(in_dst)] : 1'b0;
			b_live_q <= in_src_ok ? valid_q[AW'(in_src)] : 1'b0;
		end
	end

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (rf_wr) begin
			valid_q[AW'(dst_q)] <= 1'b1;
		end
	end

	// Operand registers.
	always_ff @(posedge clk) begin
		if (cmd.latch_opnd) begin
			a_q <= a_live_q ? rd_a : '0;
			b_q <= b_live_q ? rd_b : '0;
		end
	end

	// One restoring divide step on the magnitudes.
	assign div_shift = {x_q, y_q[DATA_W-1]};
	assign div_trial = div_shift - {1'b0, z_q};

	// Shared shift unit: accumulator or remainder in x, multiplicand or
	// quotient in y, multiplier or divisor in z.
	always_ff @(posedge clk) begin
		if (cmd.init_mul) begin
			x_q <= '0;
			y_q <= a_q;
			z_q <= b_q;
		end else if (cmd.init_div) begin
			x_q   <= '0;
			y_q   <= a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
			z_q   <= b_q[DATA_W-1] ? (DATA_W'(0) - b_q) : b_q;
			neg_q <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
		end else if (cmd.step) begin
			if (op_q == OP_MUL) begin
				if (z_q[0]) begin
					x_q <= x_q + y_q;
				end
				y_q <= {y_q[DATA_W-2:0], 1'b0};
				z_q <= {1'b0, z_q[DATA_W-1:1]};
			end else begin
				if (!div_trial[DATA_W]) begin
					x_q <= div_trial[DATA_W-1:0];
					y_q <= {y_q[DATA_W-2:0], 1'b1};
				end else begin
					x_q <= div_shift[DATA_W-1:0];
					y_q <= {y_q[DATA_W-2:0], 1'b0};
				end
			end
		end
	end

	// Result selection for the write-back.
	always_comb begin
		case (op_q)
			OP_LDI:  wr_data = imm_q;
			OP_MOV:  wr_data = b_q;
			OP_ADD:  wr_data = a_q + b_q;
			OP_SUB:  wr_data = a_q - b_q;
			OP_MUL:  wr_data = x_q;
			OP_DIV:  wr_data = neg_q ? (DATA_W'(0) - y_q) : y_q;
			default: wr_data = a_q;
		endcase
	end

	// Writes to an index beyond the register count are dropped.
	assign rf_wr = cmd.wr_en && dst_ok_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= a_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = OUT_TDATA_W'(out_value_q);

	// Status to the controller.
	assign stat.op       = op_q;
	assign stat.b_zero   = (b_q == '0);
	assign stat.out_busy = out_valid_q && !out_ready;

	// A new output item never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !out_ready))
		else $error("output register overwritten while stalled");

	// A multiply with a zero multiplier starts from a zero accumulator.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init_mul && b_q == '0) |=> (x_q == '0 && z_q == '0))
		else $error("multiply start with zero multiplier left residue");

	// A division step keeps the remainder below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && op_q == OP_DIV && z_q != '0) |=> (x_q < z_q))
		else $error("divide remainder not below divisor");

endmodule

// ----- sv/fram_ctrl.sv -----
// -----------------------------------------------------------------------------
// fram_ctrl: controller of the four-register ALU machine
//
// Accepts one item at a time, sequences operand read, execution, the
// bit-serial multiply and divide iterations, and the write-back or output.
// -----------------------------------------------------------------------------
module fram_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fram_pkg::ctrl_stat_t stat,
	output fram_pkg::ctrl_cmd_t  cmd
);

	import fram_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OPND = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_ITER = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DATA_W - 1);

	logic [2:0]            state_q;
	logic [2:0]            state_d;
	logic [STEP_CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_OPND;
				end
			end
			ST_OPND: begin
				cmd.latch_opnd = 1'b1;
				state_d        = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.op)
					OP_LDI, OP_MOV, OP_ADD, OP_SUB: begin
						cmd.wr_en = 1'b1;
						state_d   = ST_IDLE;
					end
					OP_MUL: begin
						cmd.init_mul = 1'b1;
						state_d      = ST_ITER;
					end
					OP_DIV: begin
						// Division by zero leaves the destination alone.
						if (stat.b_zero) begin
							state_d = ST_IDLE;
						end else begin
							cmd.init_div = 1'b1;
							state_d      = ST_ITER;
						end
					end
					OP_OUT: begin
						if (!stat.out_busy) begin
							cmd.load_out = 1'b1;
							state_d      = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_ITER: begin
				cmd.step = 1'b1;
				if (cnt_q == STEP_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// The last iteration step leads to the write-back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && cnt_q == STEP_LAST) |=> (state_q == ST_DONE))
		else $error("iteration did not end in write-back");

	// An accepted item always proceeds to its operand read.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_OPND && !in_ready))
		else $error("accepted item not taken into operand read");

	// Write-back and output never happen for the same item in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.load_out))
		else $error("write-back and output in the same cycle");

	// The counter only runs while iterating.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ITER) |=> (cnt_q == '0))
		else $error("iteration counter running outside iteration");

endmodule

// ----- tb/tb_four_register_alu_machine.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_four_register_alu_machine: self-checking bench for the register ALU block
//
// Runs a short table of hand-picked instructions, then random instruction
// streams, while both stream sides pause in random bursts. A local copy of
// the four registers predicts each output value not typed into the table.
// Each value sent is compared with the oldest prediction still waiting.
// -----------------------------------------------------------------------------
module tb_four_register_alu_machine;
	import fram_pkg::*;

	// The op code that the package leaves unnamed; the block must ignore it.
	localparam op_t OP_UNUSED = 3'd7;

	localparam int REGS          = REG_COUNT_DEF;
	localparam int RANDOM_ITEMS  = 830;
	localparam int CALM_ITEMS    = 120;
	localparam int DRAIN_CYCLES  = 80;

	localparam logic [DATA_W-1:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] MIN_NEG  = 64'h8000_0000_0000_0000;
	localparam logic [DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// Register indexes.
	localparam logic [IDX_W-1:0] AX = 2'd0;
	localparam logic [IDX_W-1:0] BX = 2'd1;
	localparam logic [IDX_W-1:0] CX = 2'd2;
	localparam logic [IDX_W-1:0] DX = 2'd3;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  dst;
		logic [IDX_W-1:0]  src;
		logic [DATA_W-1:0] imm;
	} instr_t;

	// One row of the directed table; a typed value replaces the prediction.
	typedef struct packed {
		instr_t            ins;
		bit                typed;
		logic [DATA_W-1:0] typed_val;
	} directed_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	logic [DATA_W-1:0] arch_regs [REGS];
	logic [DATA_W-1:0] out_values_due [$];
	directed_row_t     directed_rows [$];
	int                mismatch_count;
	bit                calm;

	four_register_alu_machine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#6_000_000;
		$display("tb_four_register_alu_machine: done, errors");
		$finish;
	end

	// Signed quotient that truncates toward zero, built from magnitudes so
	// that the most negative value over minus one wraps to itself.
	function automatic logic [DATA_W-1:0] quotient_toward_zero(
		input logic [DATA_W-1:0] n,
		input logic [DATA_W-1:0] d
	);
		logic              n_neg;
		logic              d_neg;
		logic [DATA_W-1:0] n_mag;
		logic [DATA_W-1:0] d_mag;
		logic [DATA_W-1:0] q;
		n_neg = n[DATA_W-1];
		d_neg = d[DATA_W-1];
		n_mag = n_neg ? -n : n;
		d_mag = d_neg ? -d : d;
		q = n_mag / d_mag;
		return (n_neg != d_neg) ? -q : q;
	endfunction

	// Registers beyond the file read as zero.
	function automatic logic [DATA_W-1:0] read_arch(input logic [IDX_W-1:0] idx);
		return (idx < REGS) ? arch_regs[idx] : '0;
	endfunction

	// Writes beyond the file are dropped.
	task automatic write_arch(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
		if (idx < REGS) arch_regs[idx] = v;
	endtask

	// Execute one instruction on the local registers; only output emits.
	task automatic apply_instruction(
		input  instr_t            ins,
		output bit                emits,
		output logic [DATA_W-1:0] value
	);
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		a = read_arch(ins.dst);
		b = read_arch(ins.src);
		emits = 1'b0;
		value = a;
		case (ins.op)
			OP_LDI: write_arch(ins.dst, ins.imm);
			OP_MOV: write_arch(ins.dst, b);
			OP_ADD: write_arch(ins.dst, a + b);
			OP_SUB: write_arch(ins.dst, a - b);
			OP_MUL: write_arch(ins.dst, a * b);
			OP_DIV: begin
				if (b != '0) write_arch(ins.dst, quotient_toward_zero(a, b));
			end
			OP_OUT: emits = 1'b1;
			default: ;
		endcase
	endtask

	task automatic add_row(
		input op_t               op,
		input logic [IDX_W-1:0]  dst,
		input logic [IDX_W-1:0]  src,
		input logic [DATA_W-1:0] imm,
		input bit                typed,
		input logic [DATA_W-1:0] typed_val
	);
		directed_row_t row;
		row.ins.op    = op;
		row.ins.dst   = dst;
		row.ins.src   = src;
		row.ins.imm   = imm;
		row.typed     = typed;
		row.typed_val = typed_val;
		directed_rows.push_back(row);
	endtask

	// Present one item, at times after a random gap, and predict on acceptance.
	task automatic send_item(
		input instr_t            ins,
		input bit                typed,
		input logic [DATA_W-1:0] typed_val
	);
		bit                emits;
		logic [DATA_W-1:0] value;
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[OP_LSB  +: OP_W]   = ins.op;
		word[DST_LSB +: IDX_W]  = ins.dst;
		word[SRC_LSB +: IDX_W]  = ins.src;
		word[IMM_LSB +: DATA_W] = ins.imm;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_instruction(ins, emits, value);
		if (emits) out_values_due.push_back(typed ? typed_val : value);
	endtask

	// Receiver side: ready most of the time, with random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// Compare every accepted output item with the oldest prediction.
	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (out_values_due.size() == 0) begin
				$display("%0t: unexpected output item, expected none, got %h",
					$time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = out_values_due.pop_front();
				if (m_axis_tdata[DATA_W-1:0] !== want) begin
					$display("%0t: out_value mismatch, expected %h, got %h",
						$time, want, m_axis_tdata[DATA_W-1:0]);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random stream, drain.
	initial begin
		instr_t ins;
		int     sel;
		int     small_v;
		int     word_v;
		mismatch_count = 0;
		calm          = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		for (int i = 0; i < REGS; i++) arch_regs[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads after reset, extremes, wrap cases, division by zero,
		// same-register operands and the unused op code.
		add_row(OP_OUT, AX, AX, '0, 1'b1, '0);
		add_row(OP_OUT, DX, DX, ALL_ONES, 1'b1, '0);
		add_row(OP_LDI, AX, CX, MAX_POS, 1'b0, '0);
		add_row(OP_OUT, AX, BX, '0, 1'b1, MAX_POS);
		add_row(OP_LDI, BX, BX, MIN_NEG, 1'b0, '0);
		add_row(OP_OUT, BX, AX, '0, 1'b1, MIN_NEG);
		add_row(OP_LDI, CX, DX, ALL_ONES, 1'b0, '0);
		add_row(OP_DIV, BX, CX, 64'h5A5A_5A5A_A5A5_A5A5, 1'b0, '0);
		add_row(OP_OUT, BX, CX, '0, 1'b1, MIN_NEG);
		add_row(OP_MUL, BX, CX, ALL_ONES, 1'b0, '0);
		add_row(OP_OUT, BX, DX, '0, 1'b1, MIN_NEG);
		add_row(OP_ADD, AX, AX, MIN_NEG, 1'b0, '0);
		add_row(OP_OUT, AX, AX, '0, 1'b0, '0);
		add_row(OP_LDI, DX, AX, 64'd7, 1'b0, '0);
		add_row(OP_LDI, AX, BX, 64'hFFFF_FFFF_FFFF_FFEC, 1'b0, '0);
		add_row(OP_DIV, AX, DX, '0, 1'b0, '0);
		add_row(OP_OUT, AX, CX, ALL_ONES, 1'b0, '0);
		add_row(OP_SUB, DX, DX, MAX_POS, 1'b0, '0);
		add_row(OP_DIV, AX, DX, '0, 1'b0, '0);
		add_row(OP_OUT, AX, AX, '0, 1'b0, '0);
		add_row(OP_DIV, CX, CX, '0, 1'b0, '0);
		add_row(OP_MOV, BX, AX, ALL_ONES, 1'b0, '0);
		add_row(OP_MOV, AX, AX, '0, 1'b0, '0);
		add_row(OP_UNUSED, BX, CX, ALL_ONES, 1'b0, '0);
		add_row(OP_OUT, BX, CX, '0, 1'b0, '0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].typed_val);

		// Random instruction stream; the last stretch runs without pauses.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
			ins.dst = IDX_W'($urandom_range(0, 3));
			ins.src = IDX_W'($urandom_range(0, 3));
			ins.imm = {$urandom, $urandom};
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				ins.op = OP_LDI;
				case ($urandom_range(0, 4))
					0: ;
					1: begin
						small_v = $urandom_range(0, 40);
						small_v = small_v - 20;
						ins.imm = DATA_W'(small_v);
					end
					2: begin
						case ($urandom_range(0, 4))
							0: ins.imm = MAX_POS;
							1: ins.imm = MIN_NEG;
							2: ins.imm = ALL_ONES;
							3: ins.imm = 64'd1;
							default: ins.imm = '0;
						endcase
					end
					3: ins.imm = 64'd1 << $urandom_range(0, 63);
					default: begin
						word_v = $urandom;
						ins.imm = DATA_W'(word_v);
					end
				endcase
			end
			else if (sel < 30) ins.op = OP_MOV;
			else if (sel < 42) ins.op = OP_ADD;
			else if (sel < 54) ins.op = OP_SUB;
			else if (sel < 64) ins.op = OP_MUL;
			else if (sel < 76) ins.op = OP_DIV;
			else if (sel < 98) ins.op = OP_OUT;
			else ins.op = OP_UNUSED;
			send_item(ins, 1'b0, '0);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		// Wait for every predicted value, then let the block settle.
		while (out_values_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_four_register_alu_machine: done, clean");
		end else begin
			$display("tb_four_register_alu_machine: done, errors");
		end
		$finish;
	end

endmodule
